// File: design/integer_to_ascii_field_unit_assert.svh
// assertion macros shared by the checker of integer_to_ascii_field_unit
// depends on signals clk and arst_n being visible where a macro is used
`ifndef INTEGER_TO_ASCII_FIELD_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_FIELD_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while reset is held
`define I2A_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2a check failed");

// next-cycle implication, sampled on clk, off while reset is held
`define I2A_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2a check failed");

`endif

// File: design/i2a_pkg.sv
// shared types, constants and helpers of the integer to ascii field unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

	localparam int VALUE_BITS = 32;
	localparam int MAX_WIDTH  = 63;
	localparam int POS_W      = $clog2(MAX_WIDTH + 1);
	// decimal digits needed for VALUE_BITS bits, 1233/4096 ~ log10(2)
	localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
	localparam int DIG_IDX_W  = $clog2(DEC_DIGITS);
	localparam int ND_W       = $clog2(DEC_DIGITS + 2);
	localparam int CNT_W      = $clog2(VALUE_BITS);

	localparam logic [POS_W-1:0] HEX_DEFAULT_WIDTH = POS_W'(8);

	localparam logic [1:0] MODE_UDEC = 2'd0;
	localparam logic [1:0] MODE_SDEC = 2'd1;
	localparam logic [1:0] MODE_HEX  = 2'd2;

	localparam logic [1:0] FILL_NONE  = 2'd0;
	localparam logic [1:0] FILL_SPACE = 2'd1;
	localparam logic [1:0] FILL_ZERO  = 2'd2;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_A_OFS   = 8'h41 - 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_HASH    = 8'h23;

	typedef logic [3:0] digit_t;
	typedef digit_t [DEC_DIGITS-1:0] digits_t;

	typedef struct packed {
		logic [1:0]            mode;
		logic [VALUE_BITS-1:0] value;
		logic [5:0]            field_width;
		logic [1:0]            fill_kind;
		logic [5:0]            room;
	} item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last_char;
	} result_t;

	// layout of one field, handed from the sequencer to the character stage
	typedef struct packed {
		logic             left;
		logic             neg;
		logic             zero;
		logic             err;
		logic             cut;
		logic [ND_W-1:0]  nd;
		logic [ND_W-1:0]  lead;
		logic [POS_W-1:0] field;
		logic [POS_W-1:0] len;
	} fmt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_PREP
	} state_t;

	function automatic logic [7:0] digit_char(input digit_t d);
		return (d > 4'd9) ? (8'(d) + CH_A_OFS) : (8'(d) + CH_ZERO);
	endfunction

endpackage

`default_nettype wire

// File: design/i2a_bcd_conv.sv
// bit-serial binary to bcd converter (shift and add three), one bit per cycle
// hex items load their nibbles straight into the digit register
// depends on i2a_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2a_bcd_conv (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            hex,
	input  logic [i2a_pkg::VALUE_BITS-1:0]  mag,
	output i2a_pkg::digits_t                digits,
	output logic                            done
);

	localparam int DB = 4 * i2a_pkg::DEC_DIGITS;

	logic [i2a_pkg::VALUE_BITS-1:0] bin_q;
	i2a_pkg::digits_t               bcd_q;
	i2a_pkg::digits_t               adj;
	logic [DB-1:0]                  adj_flat;
	logic [i2a_pkg::CNT_W-1:0]      cnt_q;
	logic                           busy_q;
	logic                           done_q;

	always_comb begin
		for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
		adj_flat = adj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (hex) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == i2a_pkg::CNT_W'(i2a_pkg::VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			if (hex) begin
				bcd_q <= i2a_pkg::digits_t'(mag);
			end else begin
				bcd_q <= '0;
			end
		end else if (busy_q) begin
			bcd_q <= i2a_pkg::digits_t'({adj_flat[DB-2:0], bin_q[i2a_pkg::VALUE_BITS-1]});
			bin_q <= {bin_q[i2a_pkg::VALUE_BITS-2:0], 1'b0};
		end
	end

	assign digits = bcd_q;
	assign done   = done_q;

endmodule

`default_nettype wire

// File: design/i2a_emit.sv
// character stage: walks the field left to right, one character per transfer
// holds its own copy of the digits so the converter can take the next item
// depends on i2a_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2a_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  i2a_pkg::fmt_t     fmt,
	input  i2a_pkg::digits_t  digits,
	output logic              busy,
	output logic              result_valid,
	input  logic              result_ready,
	output i2a_pkg::result_t  result
);

	i2a_pkg::fmt_t              fmt_q;
	i2a_pkg::digits_t           dig_q;
	i2a_pkg::result_t           res_q;
	logic [i2a_pkg::POS_W-1:0]  pos_q;
	logic                       busy_q;
	logic                       valid_q;

	logic                       load;
	logic                       last;
	logic [7:0]                 ch;
	logic [i2a_pkg::POS_W-1:0]  k;
	logic [i2a_pkg::POS_W-1:0]  didx;
	logic [i2a_pkg::POS_W-1:0]  lead_w;
	logic [i2a_pkg::POS_W-1:0]  nd_w;

	assign load = busy_q && (!valid_q || result_ready);
	assign last = (pos_q == fmt_q.len - i2a_pkg::POS_W'(1));

	always_comb begin
		lead_w = i2a_pkg::POS_W'(fmt_q.lead);
		nd_w   = i2a_pkg::POS_W'(fmt_q.nd);
		// k counts places from the right edge of the field
		k      = fmt_q.field - pos_q - i2a_pkg::POS_W'(1);
		didx   = fmt_q.left ? (lead_w - pos_q - i2a_pkg::POS_W'(1)) : k;
		if (fmt_q.left) begin
			priority if (fmt_q.cut && last) begin
				ch = i2a_pkg::CH_HASH;
			end else if (fmt_q.neg && pos_q == '0) begin
				ch = i2a_pkg::CH_MINUS;
			end else if (pos_q < lead_w) begin
				ch = i2a_pkg::digit_char(dig_q[didx[i2a_pkg::DIG_IDX_W-1:0]]);
			end else begin
				ch = i2a_pkg::CH_SPACE;
			end
		end else begin
			priority if (fmt_q.err && pos_q == '0) begin
				ch = i2a_pkg::CH_HASH;
			end else if (fmt_q.neg && fmt_q.field > nd_w
					&& (fmt_q.zero ? (pos_q == '0) : (k == nd_w))) begin
				// sign leads with zero fill, sits before the digits with space fill
				ch = i2a_pkg::CH_MINUS;
			end else if (k < nd_w) begin
				ch = i2a_pkg::digit_char(dig_q[didx[i2a_pkg::DIG_IDX_W-1:0]]);
			end else begin
				ch = fmt_q.zero ? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (load) begin
				pos_q <= pos_q + i2a_pkg::POS_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			fmt_q <= fmt;
			dig_q <= digits;
		end
		if (load) begin
			res_q.char_out  <= ch;
			res_q.last_char <= last;
		end
	end

	assign busy         = busy_q;
	assign result_valid = valid_q;
	assign result       = res_q;

endmodule

`default_nettype wire

// File: design/integer_to_ascii_field_unit.sv
// integer to ascii field unit: top level with the item sequencer
// depends on i2a_pkg, i2a_bcd_conv and i2a_emit
//
// Usage: one item (mode, value, field width, fill kind, room) goes in on the
// item channel and comes out as a run of ascii characters on the result
// channel, left to right, with last_char set on the final one. An item with
// zero room gives no characters at all.
// A decimal item first passes through the bit-serial converter, a value bit at
// a time, before its first character shows; a hex item skips the conversion.
// Throughput: one character per cycle while the receiver takes them. The
// converter works on the next item while the character stage still sends the
// previous one, so the converter is the limit for short fields.
// Reset clears the sequencer and all valid flags; no characters are pending.
// A stalled receiver holds the current character in the output register and
// the run simply waits; the next item is still taken and converted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_field_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  i2a_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_ready,
	output i2a_pkg::result_t  result
);

	localparam int PW = i2a_pkg::POS_W;

	i2a_pkg::state_t  state_q;
	i2a_pkg::state_t  state_nxt;

	logic             hex_q;
	logic             neg_q;
	logic [PW-1:0]    w_q;
	logic [PW-1:0]    r_q;
	logic [1:0]       fk_q;

	logic                           accept;
	logic                           conv_start;
	logic                           emit_start;
	logic                           item_hex;
	logic                           item_neg;
	logic [i2a_pkg::VALUE_BITS-1:0] mag;
	i2a_pkg::digits_t               conv_digits;
	logic                           conv_done;
	logic                           emit_busy;
	i2a_pkg::fmt_t                  fmt;

	logic [i2a_pkg::ND_W-1:0] nd;
	logic [PW-1:0]            lead_w;
	logic [PW-1:0]            nd_w;
	logic [PW-1:0]            span;
	logic [PW-1:0]            wh;
	logic [PW-1:0]            field;

	assign accept   = item_valid && item_ready;
	assign item_hex = (item.mode == i2a_pkg::MODE_HEX);
	assign item_neg = (item.mode == i2a_pkg::MODE_SDEC) && item.value[i2a_pkg::VALUE_BITS-1];
	assign mag      = item_neg ? (~item.value + 1'b1) : item.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2a_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hex_q <= item_hex;
			neg_q <= item_neg;
			w_q   <= item.field_width;
			r_q   <= item.room;
			fk_q  <= item.fill_kind;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		item_ready = 1'b0;
		conv_start = 1'b0;
		emit_start = 1'b0;
		unique case (state_q)
			i2a_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid && item.room != '0) begin
					conv_start = 1'b1;
					state_nxt  = i2a_pkg::ST_CONV;
				end
			end
			i2a_pkg::ST_CONV: begin
				if (conv_done) begin
					state_nxt = i2a_pkg::ST_PREP;
				end
			end
			i2a_pkg::ST_PREP: begin
				if (!emit_busy) begin
					emit_start = 1'b1;
					state_nxt  = i2a_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = i2a_pkg::ST_IDLE;
			end
		endcase
	end

	// field layout from the converted digits
	always_comb begin
		nd = i2a_pkg::ND_W'(1);
		for (int i = 1; i < i2a_pkg::DEC_DIGITS; i++) begin
			if (conv_digits[i] != '0) begin
				nd = i2a_pkg::ND_W'(i + 1);
			end
		end
		fmt.nd   = nd;
		fmt.lead = nd + i2a_pkg::ND_W'(neg_q);
		fmt.neg  = neg_q;
		lead_w   = PW'(fmt.lead);
		nd_w     = PW'(nd);

		fmt.left = !hex_q && (fk_q == i2a_pkg::FILL_NONE || w_q == '0);
		fmt.cut  = lead_w > r_q;
		span     = (lead_w > w_q) ? lead_w : w_q;

		wh        = (hex_q && w_q == '0) ? i2a_pkg::HEX_DEFAULT_WIDTH : w_q;
		field     = (wh > r_q) ? r_q : wh;
		fmt.field = field;
		fmt.zero  = hex_q ? (fk_q == i2a_pkg::FILL_NONE || fk_q == i2a_pkg::FILL_ZERO)
				: (fk_q == i2a_pkg::FILL_ZERO);
		// hex keeps the low digits silently, decimal marks the loss
		fmt.err   = !hex_q && (nd_w > field || (neg_q && field <= nd_w));
		fmt.len   = fmt.left ? ((span > r_q) ? r_q : span) : field;
	end

	i2a_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.hex    (item_hex),
		.mag    (mag),
		.digits (conv_digits),
		.done   (conv_done)
	);

	i2a_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (emit_start),
		.fmt          (fmt),
		.digits       (conv_digits),
		.busy         (emit_busy),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

// File: design/i2a_checker.sv
// port-level checks of integer_to_ascii_field_unit, bound to the top level
// depends on i2a_pkg and integer_to_ascii_field_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_ascii_field_unit_assert.svh"

module i2a_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input i2a_pkg::item_t    item,
	input logic              result_valid,
	input logic              result_ready,
	input i2a_pkg::result_t  result
);

	// a stalled character stays put until its transfer
	`I2A_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// the sequencer takes one item with room at a time, so it is busy right after it
	`I2A_ASSERT_NXT(a_busy_after_item, item_valid && item_ready && item.room != '0, !item_ready)

	// only digits, hex letters, space, sign and the overflow mark ever leave
	`I2A_ASSERT_IMP(a_char_set, result_valid, (result.char_out >= i2a_pkg::CH_ZERO && result.char_out <= i2a_pkg::CH_NINE) || (result.char_out >= i2a_pkg::CH_UPPER_A && result.char_out <= i2a_pkg::CH_UPPER_F) || result.char_out == i2a_pkg::CH_SPACE || result.char_out == i2a_pkg::CH_MINUS || result.char_out == i2a_pkg::CH_HASH)

endmodule

bind integer_to_ascii_field_unit i2a_checker u_i2a_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

// File: tb/tb.sv
// testbench for integer_to_ascii_field_unit: random and directed conversions checked
// character by character against a behavioural formatter; depends on i2a_pkg
`timescale 1ns / 1ps

module tb;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [1:0] FILL_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 445;
	localparam int DRAIN_CYCLES = 100;

	logic             clk;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_ready;
	i2a_pkg::item_t   item         = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	i2a_pkg::result_t result;

	i2a_pkg::item_t   item_queue[$];
	i2a_pkg::result_t expected_chars[$];
	logic    item_xfer = 1'b0;
	logic    res_xfer  = 1'b0;
	int      send_gap  = 0;
	int      send_calm = 0;
	int      stall_left = 0;
	int      recv_calm = 0;
	int      items_taken = 0;
	int      chars_checked = 0;
	int      errors = 0;

	integer_to_ascii_field_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// works out the characters of one item and queues them as expectations
	function automatic void predict_chars(input i2a_pkg::item_t it);
		logic [7:0]  txt [0:i2a_pkg::MAX_WIDTH+7];
		logic [3:0]  dg [0:11];
		logic [31:0] v;
		logic [31:0] mag;
		logic [3:0]  d;
		logic [7:0]  fc;
		logic        neg;
		logic        cut;
		logic        zero;
		int          w;
		int          r;
		int          nd;
		int          pos;
		int          field;
		int          shown;
		int          len;
		int          i;
		w = int'(it.field_width);
		r = int'(it.room);
		v = it.value;
		if (r == 0)
			return;
		if (it.mode == i2a_pkg::MODE_HEX) begin
			field = (w == 0) ? int'(i2a_pkg::HEX_DEFAULT_WIDTH) : w;
			if (field > r)
				field = r;
			fc = (it.fill_kind == i2a_pkg::FILL_NONE || it.fill_kind == i2a_pkg::FILL_ZERO)
				? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE;
			for (i = 0; i < field; i++)
				txt[i] = fc;
			pos = field;
			if (v == 0) begin
				txt[pos-1] = i2a_pkg::CH_ZERO;
			end else begin
				// only the low nibbles survive a short field
				while (pos > 0 && v != 0) begin
					d = v[3:0];
					v = v >> 4;
					txt[pos-1] = (d > 4'd9) ? i2a_pkg::CH_UPPER_A + 8'(d - 4'd10)
						: i2a_pkg::CH_ZERO + 8'(d);
					pos--;
				end
			end
			len = field;
		end else begin
			neg = (it.mode == i2a_pkg::MODE_SDEC) && v[31];
			mag = neg ? -v : v;
			nd = 0;
			while (nd == 0 || mag != 0) begin
				dg[nd] = 4'(mag % 10);
				mag = mag / 10;
				nd++;
			end
			if (it.fill_kind == i2a_pkg::FILL_NONE || w == 0) begin
				cut = 1'b0;
				pos = 0;
				if (neg) begin
					txt[pos] = i2a_pkg::CH_MINUS;
					pos++;
				end
				for (i = nd; i > 0; i--) begin
					if (pos < r) begin
						txt[pos] = i2a_pkg::CH_ZERO + 8'(dg[i-1]);
						pos++;
					end else begin
						cut = 1'b1;
					end
				end
				if (cut)
					txt[pos-1] = i2a_pkg::CH_HASH;
				while (pos < w && pos < r) begin
					txt[pos] = i2a_pkg::CH_SPACE;
					pos++;
				end
				len = pos;
			end else begin
				field = (w > r) ? r : w;
				shown = (nd > field) ? field : nd;
				zero  = (it.fill_kind == i2a_pkg::FILL_ZERO);
				for (i = 0; i < field; i++)
					txt[i] = zero ? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE;
				for (i = 0; i < shown; i++)
					txt[field-1-i] = i2a_pkg::CH_ZERO + 8'(dg[i]);
				// zero fill puts the sign at the far left, space fill next to the digits
				if (neg && field > nd) begin
					if (zero)
						txt[0] = i2a_pkg::CH_MINUS;
					else
						txt[field-nd-1] = i2a_pkg::CH_MINUS;
				end
				if (nd > field || (neg && field <= nd))
					txt[0] = i2a_pkg::CH_HASH;
				len = field;
			end
		end
		for (i = 0; i < len; i++)
			expected_chars.push_back(i2a_pkg::result_t'{char_out: txt[i],
				last_char: (i == len - 1)});
	endfunction

	// idle cycles before the next transfer, with occasional runs of none
	function automatic int draw_idle(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	function automatic void add_item(input logic [1:0] m, input logic [31:0] v,
		input logic [5:0] w, input logic [1:0] fk, input logic [5:0] r);
		item_queue.push_back(i2a_pkg::item_t'{mode: m, value: v, field_width: w,
			fill_kind: fk, room: r});
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_xfer) begin
			if (send_gap > 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (item_queue.size() != 0) begin
				item       <= item_queue.pop_front();
				item_valid <= 1'b1;
				send_gap = draw_idle(send_calm);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (res_xfer)
				stall_left = draw_idle(recv_calm);
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		i2a_pkg::result_t exp_char;
		item_xfer <= arst_n && item_valid && item_ready;
		res_xfer  <= arst_n && result_valid && result_ready;
		if (arst_n && item_valid && item_ready) begin
			predict_chars(item);
			items_taken++;
		end
		if (arst_n && result_valid === 1'b1 && result_ready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected character %h last %b", $time,
					result.char_out, result.last_char);
				errors++;
			end else begin
				exp_char = expected_chars.pop_front();
				chars_checked++;
				if (result.char_out !== exp_char.char_out) begin
					$display("%0t: char_out expected %h got %h", $time,
						exp_char.char_out, result.char_out);
					errors++;
				end
				if (result.last_char !== exp_char.last_char) begin
					$display("%0t: last_char expected %b got %b", $time,
						exp_char.last_char, result.last_char);
					errors++;
				end
			end
		end
	end

	initial begin
		i2a_pkg::item_t it;
		logic [31:0]    pow10;
		int             sel;
		int             k;

		// directed: extremes, every mode and the awkward layouts
		add_item(i2a_pkg::MODE_UDEC, 32'd0, 6'd0, i2a_pkg::FILL_NONE, 6'd63);
		add_item(i2a_pkg::MODE_UDEC, 32'hFFFF_FFFF, 6'd0, i2a_pkg::FILL_NONE, 6'd63);
		add_item(i2a_pkg::MODE_SDEC, 32'h8000_0000, 6'd0, i2a_pkg::FILL_NONE, 6'd63);
		add_item(i2a_pkg::MODE_SDEC, 32'h8000_0000, 6'd14, i2a_pkg::FILL_ZERO, 6'd63);
		add_item(i2a_pkg::MODE_SDEC, 32'hFFFF_FFFF, 6'd5, i2a_pkg::FILL_SPACE, 6'd63);
		add_item(i2a_pkg::MODE_SDEC, -32'sd42, 6'd8, i2a_pkg::FILL_ZERO, 6'd63);
		add_item(i2a_pkg::MODE_HEX, 32'd0, 6'd0, i2a_pkg::FILL_NONE, 6'd63);
		add_item(i2a_pkg::MODE_HEX, 32'hDEAD_BEEF, 6'd0, i2a_pkg::FILL_NONE, 6'd63);
		add_item(i2a_pkg::MODE_HEX, 32'hABCD_EF12, 6'd4, i2a_pkg::FILL_SPACE, 6'd63);
		add_item(i2a_pkg::MODE_HEX, 32'h5555_5555, 6'd63, FILL_SPARE, 6'd63);
		add_item(i2a_pkg::MODE_HEX, 32'hAAAA_AAAA, 6'd0, i2a_pkg::FILL_ZERO, 6'd1);
		add_item(i2a_pkg::MODE_UDEC, 32'd999, 6'd10, i2a_pkg::FILL_SPACE, 6'd0);
		add_item(MODE_SPARE, 32'd12345, 6'd10, i2a_pkg::FILL_SPACE, 6'd63);
		add_item(i2a_pkg::MODE_SDEC, -32'sd7, 6'd6, FILL_SPARE, 6'd63);
		add_item(i2a_pkg::MODE_UDEC, 32'd4000000000, 6'd0, i2a_pkg::FILL_NONE, 6'd5);
		add_item(i2a_pkg::MODE_SDEC, -32'sd7, 6'd0, i2a_pkg::FILL_NONE, 6'd1);
		add_item(i2a_pkg::MODE_UDEC, 32'd123456, 6'd3, i2a_pkg::FILL_SPACE, 6'd63);
		add_item(i2a_pkg::MODE_SDEC, -32'sd123, 6'd3, i2a_pkg::FILL_ZERO, 6'd63);
		add_item(i2a_pkg::MODE_SDEC, -32'sd123, 6'd4, i2a_pkg::FILL_SPACE, 6'd63);
		add_item(i2a_pkg::MODE_UDEC, 32'd77, 6'd0, i2a_pkg::FILL_ZERO, 6'd63);
		add_item(i2a_pkg::MODE_UDEC, 32'd9, 6'd6, i2a_pkg::FILL_NONE, 6'd63);
		add_item(i2a_pkg::MODE_UDEC, 32'd9, 6'd20, i2a_pkg::FILL_NONE, 6'd4);
		add_item(i2a_pkg::MODE_SDEC, -32'sd5, 6'd30, i2a_pkg::FILL_SPACE, 6'd10);
		add_item(i2a_pkg::MODE_SDEC, 32'hFFFF_FFFF, 6'd63, i2a_pkg::FILL_ZERO, 6'd63);
		add_item(i2a_pkg::MODE_SDEC, 32'h7FFF_FFFF, 6'd11, i2a_pkg::FILL_SPACE, 6'd63);

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			sel = $urandom_range(0, 9);
			it.mode = (sel == 0) ? MODE_SPARE : (sel < 4) ? i2a_pkg::MODE_UDEC :
				(sel < 7) ? i2a_pkg::MODE_SDEC : i2a_pkg::MODE_HEX;
			case ($urandom_range(0, 5))
				0: it.value = $urandom_range(0, 999);
				1: it.value = 32'h8000_0000 ^ 32'($urandom_range(0, 7));
				2: it.value = ~32'($urandom_range(0, 999));
				3: begin
					pow10 = 32'd1;
					repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
					it.value = pow10 + 32'($urandom_range(0, 2)) - 32'd1;
				end
				default: it.value = $urandom();
			endcase
			it.field_width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
				6'($urandom_range(0, 12));
			sel = $urandom_range(0, 19);
			it.room = (sel == 0) ? 6'd0 : (sel < 5) ? 6'($urandom_range(1, 63)) :
				6'($urandom_range(1, 16));
			it.fill_kind = 2'($urandom_range(0, 3));
			item_queue.push_back(it);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (item_queue.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		// zero-room items and late strays show up here
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("conversions accepted: %0d, characters checked: %0d, errors: %0d",
			items_taken, chars_checked, errors);
		if (errors == 0 && expected_chars.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("timeout with %0d characters outstanding", expected_chars.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/i2a_pkg.sv
design/i2a_bcd_conv.sv
design/i2a_emit.sv
design/integer_to_ascii_field_unit.sv
design/i2a_checker.sv
tb/tb.sv
